// File: hw/rtl/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies; every other file of the block imports this package.

package lpfr_pkg;

   // frame layout constants
   localparam logic [2:0]  HEAD_COUNT = 3'd3;   // command byte and two length bytes
   localparam logic [15:0] TAIL_BYTES = 16'd2;  // checksum byte and end byte

   // widths of the fixed item fields
   localparam int BYTE_W    = 8;
   localparam int MAXLEN_W  = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_START_MARKER   = 2'd0,
      REG_END_MARKER     = 2'd1,
      REG_MAX_PAYLOAD    = 2'd2,
      REG_TIMEOUT_RELOAD = 2'd3
   } reg_index_type;

   // frame error codes
   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_LENGTH  = 2'd1,
      ERR_BAD_END = 2'd2,
      ERR_TIMEOUT = 2'd3
   } frame_error_type;

   // item kinds on the input channel
   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   // parser phases, one-hot
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ADDR = 4'b0010,
      PH_HEAD = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   // configuration register set
   typedef struct packed {
      logic [BYTE_W-1:0]   start_marker;
      logic [BYTE_W-1:0]   end_marker;
      logic [MAXLEN_W-1:0] max_payload_len;
      logic [BYTE_W-1:0]   timeout_reload;
   } cfg_type;

   // per-item result without the store position
   typedef struct packed {
      logic              store_valid;
      logic [BYTE_W-1:0] store_data;
      logic              frame_ok;
      frame_error_type   frame_error;
   } result_type;

endpackage

// File: hw/rtl/lpfr_parser.sv
// Frame parser state and per-item result logic of the frame receiver.
// Depends on lpfr_pkg for the configuration, result and phase types.

module lpfr_parser
   import lpfr_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int ADDR_BYTES  = 6,
   localparam int POS_W      = $clog2(STORE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  action_type        action,
   input  logic [BYTE_W-1:0] rx_byte,
   input  cfg_type           cfg,
   output result_type        result,
   output logic [POS_W-1:0]  store_addr
);

   phase_type         phase_ff, phase_in;
   logic [2:0]        field_count_ff, field_count_in;
   logic [15:0]       remaining_len_ff, remaining_len_in;
   logic [POS_W-1:0]  write_pos_ff, write_pos_in;
   logic [BYTE_W-1:0] gap_timer_ff, gap_timer_in;

   logic [POS_W-1:0]  pos_inc;
   logic [2:0]        count_dec;
   logic [15:0]       len_sum;
   logic [15:0]       len_dec;

   // helpers for the per-byte update
   assign pos_inc   = (write_pos_ff == POS_W'(STORE_DEPTH - 1)) ? '0 : write_pos_ff + POS_W'(1);
   assign count_dec = field_count_ff - 3'd1;
   assign len_sum   = remaining_len_ff + 16'(rx_byte);
   assign len_dec   = remaining_len_ff - 16'd1;

   // next state and result for the item being accepted
   always_comb begin
      phase_in         = phase_ff;
      field_count_in   = field_count_ff;
      remaining_len_in = remaining_len_ff;
      write_pos_in     = write_pos_ff;
      gap_timer_in     = gap_timer_ff;
      result           = '0;
      store_addr       = '0;

      priority if (action == ACT_TICK) begin
         if (gap_timer_ff != '0) begin
            gap_timer_in = gap_timer_ff - BYTE_W'(1);
         end
      end else if (write_pos_ff != '0 && gap_timer_ff == '0) begin
         // gap ran out mid-frame: drop the byte and restart
         phase_in           = PH_IDLE;
         write_pos_in       = '0;
         result.frame_error = ERR_TIMEOUT;
      end else begin
         gap_timer_in       = cfg.timeout_reload;
         result.store_valid = 1'b1;
         result.store_data  = rx_byte;
         store_addr         = write_pos_ff;
         write_pos_in       = pos_inc;

         unique case (phase_ff)
            PH_ADDR: begin
               field_count_in = count_dec;
               if (count_dec == 3'd0) begin
                  phase_in       = PH_HEAD;
                  field_count_in = HEAD_COUNT;
               end
            end
            PH_HEAD: begin
               field_count_in = count_dec;
               if (count_dec == 3'd1) begin
                  remaining_len_in = {rx_byte, 8'h00};
               end else if (count_dec == 3'd0) begin
                  if (len_sum <= 16'(cfg.max_payload_len)) begin
                     phase_in         = PH_DATA;
                     remaining_len_in = len_sum + TAIL_BYTES;
                  end else begin
                     remaining_len_in   = len_sum;
                     phase_in           = PH_IDLE;
                     write_pos_in       = '0;
                     result.frame_error = ERR_LENGTH;
                  end
               end
            end
            PH_DATA: begin
               remaining_len_in = len_dec;
               if (len_dec == 16'd0) begin
                  if (rx_byte == cfg.end_marker) begin
                     result.frame_ok = 1'b1;
                  end else begin
                     result.frame_error = ERR_BAD_END;
                  end
                  phase_in     = PH_IDLE;
                  write_pos_in = '0;
               end
            end
            default: begin
               // idle: look for the start byte
               if (rx_byte == cfg.start_marker) begin
                  phase_in       = PH_ADDR;
                  field_count_in = 3'(ADDR_BYTES);
               end else begin
                  write_pos_in = '0;
               end
            end
         endcase
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         field_count_ff   <= '0;
         remaining_len_ff <= '0;
         write_pos_ff     <= '0;
         gap_timer_ff     <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         remaining_len_ff <= remaining_len_in;
         write_pos_ff     <= write_pos_in;
         gap_timer_ff     <= gap_timer_in;
      end
   end

endmodule

// File: hw/rtl/length_prefixed_frame_receiver_top.sv
// Top level of the length-prefixed frame receiver: register port, parser, result buffer.
// Depends on lpfr_pkg and lpfr_parser.

// Takes one item per clock while req_tready is high (a received byte or a timeout tick)
// and returns exactly one result item for each through an output register backed by
// a one-entry skid buffer: while a result waits the input takes one more item, then
// stalls until the receiver takes the waiting result. A byte result (unless dropped
// on a timeout) gives the frame store position and data to write (store_valid in
// rsp_tuser), plus a frame-complete flag and an error code; tick results are all
// zero. Frames are a start byte, ADDR_BYTES address bytes, a command byte, a big-endian
// 16-bit length, the data, a checksum byte and an end byte. Registers are written
// through the APB-style csr port and must only change while the block is idle.

module length_prefixed_frame_receiver_top
   import lpfr_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int ADDR_BYTES  = 6,
   localparam int POS_W        = $clog2(STORE_DEPTH),
   localparam int RSP_FIELDS_W = POS_W + BYTE_W + 3,
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,

   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // rx_byte
   input  logic                   req_tuser,   // action

   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // store_addr, store_data, frame_ok, frame_error
   output logic                   rsp_tuser,   // store_valid

   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type                cfg_ff;
   reg_index_type          reg_sel;
   logic                   cfg_write;

   logic                   req_accept;
   logic                   rsp_take;
   result_type             result;
   logic [POS_W-1:0]       store_addr;
   logic [RSP_TDATA_W-1:0] new_tdata;

   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_tdata_ff;
   logic                   out_tuser_ff;
   logic                   skid_valid_ff;
   logic [RSP_TDATA_W-1:0] skid_tdata_ff;
   logic                   skid_tuser_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker    <= '0;
         cfg_ff.end_marker      <= '0;
         cfg_ff.max_payload_len <= MAXLEN_W'(1012);
         cfg_ff.timeout_reload  <= BYTE_W'(5);
      end else if (cfg_write) begin
         unique case (reg_sel)
            REG_START_MARKER:   cfg_ff.start_marker    <= csr_pwdata[BYTE_W-1:0];
            REG_END_MARKER:     cfg_ff.end_marker      <= csr_pwdata[BYTE_W-1:0];
            REG_MAX_PAYLOAD:    cfg_ff.max_payload_len <= csr_pwdata[MAXLEN_W-1:0];
            REG_TIMEOUT_RELOAD: cfg_ff.timeout_reload  <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (reg_sel)
         REG_START_MARKER:   csr_prdata = CSR_DATA_W'(cfg_ff.start_marker);
         REG_END_MARKER:     csr_prdata = CSR_DATA_W'(cfg_ff.end_marker);
         REG_MAX_PAYLOAD:    csr_prdata = CSR_DATA_W'(cfg_ff.max_payload_len);
         REG_TIMEOUT_RELOAD: csr_prdata = CSR_DATA_W'(cfg_ff.timeout_reload);
         default:            csr_prdata = '0;
      endcase
   end

   // handshakes
   assign req_tready = ~skid_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_take   = out_valid_ff & rsp_tready;

   lpfr_parser #(
      .STORE_DEPTH (STORE_DEPTH),
      .ADDR_BYTES  (ADDR_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .action     (action_type'(req_tuser)),
      .rx_byte    (req_tdata),
      .cfg        (cfg_ff),
      .result     (result),
      .store_addr (store_addr)
   );

   // pack the result item
   assign new_tdata = RSP_TDATA_W'({result.frame_error, result.frame_ok,
                                    result.store_data, store_addr});

   // output register with one-entry skid buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_ff  <= skid_valid_ff | req_accept;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_tdata_ff <= skid_tdata_ff;
            out_tuser_ff <= skid_tuser_ff;
         end else begin
            out_tdata_ff <= new_tdata;
            out_tuser_ff <= result.store_valid;
         end
      end else if (req_accept) begin
         skid_tdata_ff <= new_tdata;
         skid_tuser_ff <= result.store_valid;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_tdata_ff;
   assign rsp_tuser  = out_tuser_ff;

endmodule
